// ===== design/bps_pkg.sv =====
package bps_pkg;

    // Limits and number formats of the block.
    localparam int MAX_PATCH_SIDE = 16;
    localparam int MAX_SUBDIV     = 2;
    localparam int COORD_BITS     = 16;
    localparam int SPAN           = 3;

    localparam int INDEX_BITS   = 14;
    localparam int COLS_BITS    = 5;
    localparam int SUBDIV_BITS  = 2;
    localparam int PATCH_BITS   = 4;
    localparam int STEP_BITS    = 3;   // holds 0..SPAN*MAX_SUBDIV
    localparam int WEIGHT_BITS  = 6;   // holds up to (SPAN*MAX_SUBDIV)**2
    localparam int SHIFT_BITS   = 2;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATCH_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SUBDIV_ACROSS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SUBDIV_DOWN   = 2'd2;

    // Blend arithmetic. The rounded quotient floor((2n+d)/(2d)) with
    // 2d = 9 * 2**k is a floor shift by k followed by a floor divide by 9.
    // The divide by 9 runs on a value lifted positive by 9 * 2**18 and uses
    // a reciprocal multiply; the lift falls out of the low coordinate bits.
    localparam int PROD_BITS  = COORD_BITS + WEIGHT_BITS + 1;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int MID_BITS   = SUM_BITS + 2;
    localparam int LIFT_BITS  = 22;
    localparam int RECIP_SHIFT = 25;
    localparam logic [LIFT_BITS-1:0] LIFT_OFFSET = 22'd2359296;   // 9 * 2**18
    localparam logic [LIFT_BITS-1:0] RECIP_NINE  = 22'd3728271;   // ceil(2**25 / 9)

    typedef struct packed {
        logic [PATCH_BITS-1:0]        patch_row;
        logic [PATCH_BITS-1:0]        patch_col;
        logic signed [COORD_BITS-1:0] top_left_x;
        logic signed [COORD_BITS-1:0] top_left_y;
        logic signed [COORD_BITS-1:0] top_right_x;
        logic signed [COORD_BITS-1:0] top_right_y;
        logic signed [COORD_BITS-1:0] bottom_left_x;
        logic signed [COORD_BITS-1:0] bottom_left_y;
        logic signed [COORD_BITS-1:0] bottom_right_x;
        logic signed [COORD_BITS-1:0] bottom_right_y;
    } bps_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [INDEX_BITS-1:0]        point_index;
        logic                         last_point;
    } bps_out_t;

    // Corner weights of one point plus the divisor controls.
    typedef struct packed {
        logic [WEIGHT_BITS-1:0] w_tl;
        logic [WEIGHT_BITS-1:0] w_tr;
        logic [WEIGHT_BITS-1:0] w_bl;
        logic [WEIGHT_BITS-1:0] w_br;
        logic [WEIGHT_BITS-1:0] dsum;
        logic [SHIFT_BITS-1:0]  shift;
    } bps_weights_t;

    // Side data that travels alongside the blend pipeline.
    typedef struct packed {
        logic [INDEX_BITS-1:0] point_index;
        logic                  last_point;
    } bps_meta_t;

endpackage

// ===== design/bps_blend.sv =====
module bps_blend
(
    input  logic                                  clk,
    input  logic                                  en,
    input  bps_pkg::bps_weights_t                 weights,
    input  logic signed [bps_pkg::COORD_BITS-1:0] tl,
    input  logic signed [bps_pkg::COORD_BITS-1:0] tr,
    input  logic signed [bps_pkg::COORD_BITS-1:0] bl,
    input  logic signed [bps_pkg::COORD_BITS-1:0] br,
    output logic [bps_pkg::COORD_BITS-1:0]        result
);
    import bps_pkg::*;

    logic signed [PROD_BITS-1:0] p_tl_reg, p_tr_reg, p_bl_reg, p_br_reg;
    logic signed [PROD_BITS-1:0] p_tl_next, p_tr_next, p_bl_next, p_br_next;
    logic [WEIGHT_BITS-1:0]      dsum_reg;
    logic [SHIFT_BITS-1:0]       shift_reg;

    logic signed [SUM_BITS-1:0]  n_sum;
    logic signed [MID_BITS-1:0]  m_val;
    logic signed [MID_BITS-1:0]  v_val;
    logic [LIFT_BITS-1:0]        lift_reg, lift_next;

    logic [2*LIFT_BITS-1:0]      quot_reg, quot_next;

    // Stage A: the four weighted corners.
    assign p_tl_next = tl * $signed({1'b0, weights.w_tl});
    assign p_tr_next = tr * $signed({1'b0, weights.w_tr});
    assign p_bl_next = bl * $signed({1'b0, weights.w_bl});
    assign p_br_next = br * $signed({1'b0, weights.w_br});

    // Stage B: sum, add half the divisor, floor shift and lift positive.
    always_comb
    begin
        n_sum = SUM_BITS'(p_tl_reg) + SUM_BITS'(p_tr_reg)
              + SUM_BITS'(p_bl_reg) + SUM_BITS'(p_br_reg);
        m_val = {n_sum[SUM_BITS-1], n_sum, 1'b0}
              + {{(MID_BITS-WEIGHT_BITS){1'b0}}, dsum_reg};
        v_val = m_val >>> shift_reg;
        lift_next = v_val[LIFT_BITS-1:0] + LIFT_OFFSET;
    end

    // Stage C: divide by nine through the reciprocal.
    assign quot_next = lift_reg * RECIP_NINE;
    assign result = quot_reg[RECIP_SHIFT +: COORD_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_tl_reg  <= p_tl_next;
            p_tr_reg  <= p_tr_next;
            p_bl_reg  <= p_bl_next;
            p_br_reg  <= p_br_next;
            dsum_reg  <= weights.dsum;
            shift_reg <= weights.shift;
            lift_reg  <= lift_next;
            quot_reg  <= quot_next;
        end
    end

endmodule

// ===== design/bilinear_patch_subdivider.sv =====
// A patch's first point goes through stage 1 and the blend stages to the output register.
// Throughput: one point per cycle unless the output stalls; the point sequencer gives a patch
// (3*subdiv_down+1)*(3*subdiv_across+1) points (16, 28 or 49), and the next patch is taken
// on the cycle its predecessor's last point enters the pipeline, so patches follow with no gap.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets all three
// configuration registers to 1.
module bilinear_patch_subdivider
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  bps_pkg::bps_in_t                      in_data,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output bps_pkg::bps_out_t                     out_data,

    input  logic                                  cfg_we,
    input  logic [bps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [bps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import bps_pkg::*;

    // Configuration registers, kept as written; clamping happens on use.
    logic [COLS_BITS-1:0]   patch_columns_reg;
    logic [SUBDIV_BITS-1:0] subdiv_across_reg;
    logic [SUBDIV_BITS-1:0] subdiv_down_reg;

    // Effective grid geometry. A factor of zero acts as one and anything
    // above two acts as two, so the upper bit alone selects the factor.
    logic                   across_two;
    logic                   down_two;
    logic [STEP_BITS-1:0]   nx;
    logic [STEP_BITS-1:0]   ny;
    logic [COLS_BITS-1:0]   cols;
    logic [7:0]             cols_nx;
    logic [6:0]             grid_width;
    logic [WEIGHT_BITS-1:0] dsum;
    logic [SHIFT_BITS-1:0]  shift;

    // Pipeline advance: every stage moves when the output register is free.
    logic en;

    // Stage 0: the patch being swept and its point counters.
    logic                 hold_valid_reg, hold_valid_next;
    bps_in_t              patch_reg, patch_next;
    logic [STEP_BITS-1:0] y_reg, y_next;
    logic [STEP_BITS-1:0] x_reg, x_next;
    logic                 seq_last;
    logic                 in_fire;

    // Stage 1: weights, index and corners of one point.
    logic         s1_valid_reg;
    bps_meta_t    s1_meta_reg, s1_meta_next;
    bps_weights_t s1_w_reg, s1_w_next;
    bps_in_t      s1_patch_reg;

    logic [STEP_BITS-1:0] ry, rx;
    logic [6:0]           row_idx;
    logic [6:0]           col_idx;
    logic [14:0]          index_full;

    // Stages 2 to 4 run inside the blend units; side data keeps pace here.
    logic      pipe_valid_reg [3];
    bps_meta_t pipe_meta_reg  [3];

    logic [COORD_BITS-1:0] blend_x;
    logic [COORD_BITS-1:0] blend_y;

    logic     out_valid_reg;
    bps_out_t out_data_reg;

    // ------------------------------------------------------------------
    // Configuration writes. Indexes past the register list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_columns_reg <= COLS_BITS'(1);
            subdiv_across_reg <= SUBDIV_BITS'(1);
            subdiv_down_reg   <= SUBDIV_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATCH_COLUMNS: patch_columns_reg <= cfg_data;
                CFG_SUBDIV_ACROSS: subdiv_across_reg <= cfg_data[SUBDIV_BITS-1:0];
                CFG_SUBDIV_DOWN:   subdiv_down_reg   <= cfg_data[SUBDIV_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        across_two = subdiv_across_reg[1];
        down_two   = subdiv_down_reg[1];
        nx = across_two ? STEP_BITS'(2 * SPAN) : STEP_BITS'(SPAN);
        ny = down_two   ? STEP_BITS'(2 * SPAN) : STEP_BITS'(SPAN);
        if (patch_columns_reg == '0)
            cols = COLS_BITS'(1);
        else if (patch_columns_reg > COLS_BITS'(MAX_PATCH_SIDE))
            cols = COLS_BITS'(MAX_PATCH_SIDE);
        else
            cols = patch_columns_reg;
        cols_nx    = cols * nx;
        grid_width = cols_nx[6:0] + 7'd1;
        // The divisor nx*ny is 9, 18 or 36; twice it is 9 shifted by 1, 2 or 3.
        dsum  = nx * ny;
        shift = SHIFT_BITS'(1) + SHIFT_BITS'(across_two) + SHIFT_BITS'(down_two);
    end

    assign en = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Point sequencer: sweeps the held patch row by row, one point a cycle unless stalled.
    // A new patch is taken in the same cycle the last point moves on.
    // ------------------------------------------------------------------
    assign seq_last = (y_reg == ny) && (x_reg == nx);
    assign in_ready = !hold_valid_reg || (en && seq_last);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        patch_next      = patch_reg;
        y_next          = y_reg;
        x_next          = x_reg;
        if (hold_valid_reg && en)
        begin
            if (x_reg == nx)
            begin
                x_next = '0;
                y_next = y_reg + STEP_BITS'(1);
            end
            else
            begin
                x_next = x_reg + STEP_BITS'(1);
            end
            if (seq_last)
                hold_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            hold_valid_next = 1'b1;
            patch_next      = in_data;
            y_next          = '0;
            x_next          = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        patch_reg <= patch_next;
        y_reg     <= y_next;
        x_reg     <= x_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: corner weights and the point's index in the fine grid.
    // ------------------------------------------------------------------
    always_comb
    begin
        ry = ny - y_reg;
        rx = nx - x_reg;
        s1_w_next.w_tl  = ry * rx;
        s1_w_next.w_tr  = ry * x_reg;
        s1_w_next.w_bl  = y_reg * rx;
        s1_w_next.w_br  = y_reg * x_reg;
        s1_w_next.dsum  = dsum;
        s1_w_next.shift = shift;

        row_idx    = patch_reg.patch_row * ny + 7'(y_reg);
        col_idx    = patch_reg.patch_col * nx + 7'(x_reg);
        index_full = row_idx * grid_width + 15'(col_idx);

        s1_meta_next.point_index = index_full[INDEX_BITS-1:0];
        s1_meta_next.last_point  = seq_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                pipe_valid_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg      <= hold_valid_reg;
            pipe_valid_reg[0] <= s1_valid_reg;
            pipe_valid_reg[1] <= pipe_valid_reg[0];
            pipe_valid_reg[2] <= pipe_valid_reg[1];
            out_valid_reg     <= pipe_valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_meta_reg      <= s1_meta_next;
            s1_w_reg         <= s1_w_next;
            s1_patch_reg     <= patch_reg;
            pipe_meta_reg[0] <= s1_meta_reg;
            pipe_meta_reg[1] <= pipe_meta_reg[0];
            pipe_meta_reg[2] <= pipe_meta_reg[1];
            out_data_reg.point_x     <= blend_x;
            out_data_reg.point_y     <= blend_y;
            out_data_reg.point_index <= pipe_meta_reg[2].point_index;
            out_data_reg.last_point  <= pipe_meta_reg[2].last_point;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 4: one blend unit per coordinate.
    // ------------------------------------------------------------------
    bps_blend u_blend_x
    (
        .clk     (clk),
        .en      (en),
        .weights (s1_w_reg),
        .tl      (s1_patch_reg.top_left_x),
        .tr      (s1_patch_reg.top_right_x),
        .bl      (s1_patch_reg.bottom_left_x),
        .br      (s1_patch_reg.bottom_right_x),
        .result  (blend_x)
    );

    bps_blend u_blend_y
    (
        .clk     (clk),
        .en      (en),
        .weights (s1_w_reg),
        .tl      (s1_patch_reg.top_left_y),
        .tr      (s1_patch_reg.top_right_y),
        .bl      (s1_patch_reg.bottom_left_y),
        .br      (s1_patch_reg.bottom_right_y),
        .result  (blend_y)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Checks on the sequencer and the weight stage.
    // ------------------------------------------------------------------

    // An accepted patch starts its sweep at the top-left point.
    a_start_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> hold_valid_reg && y_reg == '0 && x_reg == '0)
        else $error("patch sweep did not start at the origin");

    // A patch is held until its last point has moved on.
    a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !(en && seq_last) |=> hold_valid_reg)
        else $error("patch dropped before its last point");

    // The four corner weights always add up to the divisor.
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (8'(s1_w_reg.w_tl) + 8'(s1_w_reg.w_tr) + 8'(s1_w_reg.w_bl)
                          + 8'(s1_w_reg.w_br)) == 8'(s1_w_reg.dsum))
        else $error("corner weights do not sum to the divisor");

    // The last point of a patch is the bottom-right corner.
    a_last_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_meta_reg.last_point |-> s1_w_reg.w_br == s1_w_reg.dsum)
        else $error("last point is not the bottom-right corner");

endmodule

// ===== tb/bps_point_checker.sv =====
`timescale 1ns / 100ps

module bps_point_checker
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    input  logic                                in_ready,
    input  bps_pkg::bps_in_t                    in_data,

    input  logic                                out_valid,
    input  logic                                out_ready,
    input  bps_pkg::bps_out_t                   out_data,

    input  logic                                cfg_we,
    input  logic [bps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bps_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    output int                                  fail_count,
    output int                                  points_pending
);
    import bps_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [COLS_BITS-1:0]   cols_setting;
    logic [SUBDIV_BITS-1:0] across_setting;
    logic [SUBDIV_BITS-1:0] down_setting;

    bps_out_t pending_points [$];

    // Zero acts as one and anything above the ceiling acts as the ceiling.
    function automatic int unsigned clamp_setting(input int unsigned value,
                                                  input int unsigned ceiling);
        if (value == 0)
            return 1;
        if (value > ceiling)
            return ceiling;
        return value;
    endfunction

    // Exact bilinear blend, rounded to nearest with ties toward plus infinity.
    function automatic logic [COORD_BITS-1:0] blend_coord(
        input longint tl, input longint tr, input longint bl, input longint br,
        input longint y, input longint x, input longint ny, input longint nx);
        longint area;
        longint weighted;
        longint num;
        longint den;
        longint rounded;
        area     = nx * ny;
        weighted = tl * (ny - y) * (nx - x) + tr * (ny - y) * x
                 + bl * y * (nx - x) + br * y * x;
        num      = 2 * weighted + area;
        den      = 2 * area;
        rounded  = num / den;
        if ((num % den) != 0 && num < 0)
            rounded = rounded - 1;
        return rounded[COORD_BITS-1:0];
    endfunction

    task automatic predict_patch_points(input bps_in_t patch);
        int unsigned cols;
        int unsigned nx;
        int unsigned ny;
        int unsigned grid_width;
        int unsigned row0;
        int unsigned col0;
        int unsigned lin_index;
        bps_out_t    pt;
        cols       = clamp_setting(cols_setting, MAX_PATCH_SIDE);
        nx         = SPAN * clamp_setting(across_setting, MAX_SUBDIV);
        ny         = SPAN * clamp_setting(down_setting, MAX_SUBDIV);
        grid_width = SPAN * cols * clamp_setting(across_setting, MAX_SUBDIV) + 1;
        row0       = patch.patch_row * ny;
        col0       = patch.patch_col * nx;
        for (int y = 0; y <= ny; y++)
        begin
            for (int x = 0; x <= nx; x++)
            begin
                pt.point_x = blend_coord($signed(patch.top_left_x),
                                         $signed(patch.top_right_x),
                                         $signed(patch.bottom_left_x),
                                         $signed(patch.bottom_right_x), y, x, ny, nx);
                pt.point_y = blend_coord($signed(patch.top_left_y),
                                         $signed(patch.top_right_y),
                                         $signed(patch.bottom_left_y),
                                         $signed(patch.bottom_right_y), y, x, ny, nx);
                lin_index      = (row0 + y) * grid_width + col0 + x;
                pt.point_index = lin_index[INDEX_BITS-1:0];
                pt.last_point  = (y == ny && x == nx);
                pending_points.push_back(pt);
            end
        end
    endtask

    task automatic check_point(input bps_out_t got);
        bps_out_t want;
        if (pending_points.size() == 0)
        begin
            if (fail_count < REPORT_LIMIT)
                $display("%0t: unexpected point x=%0d y=%0d index=%0d last=%0b", $time,
                         $signed(got.point_x), $signed(got.point_y),
                         got.point_index, got.last_point);
            fail_count++;
            return;
        end
        want = pending_points.pop_front();
        if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
            got.point_index !== want.point_index || got.last_point !== want.last_point)
        begin
            if (fail_count < REPORT_LIMIT)
                $display({"%0t: point mismatch: expected x=%0d y=%0d index=%0d last=%0b,",
                          " got x=%0d y=%0d index=%0d last=%0b"},
                         $time, $signed(want.point_x), $signed(want.point_y),
                         want.point_index, want.last_point,
                         $signed(got.point_x), $signed(got.point_y),
                         got.point_index, got.last_point);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_setting   <= 5'd1;
            across_setting <= 2'd1;
            down_setting   <= 2'd1;
            fail_count     = 0;
            points_pending <= 0;
            pending_points.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATCH_COLUMNS: cols_setting   <= cfg_data;
                    CFG_SUBDIV_ACROSS: across_setting <= cfg_data[SUBDIV_BITS-1:0];
                    CFG_SUBDIV_DOWN:   down_setting   <= cfg_data[SUBDIV_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_patch_points(in_data);
            if (out_valid && out_ready)
                check_point(out_data);
            points_pending <= pending_points.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import bps_pkg::*;

    // The run is bounded by this many clock cycles; a healthy run needs a small
    // fraction of it even with the receiver idling most of the time.
    localparam int CYCLE_LIMIT    = 1000000;
    // Cycles to wait after the last expected point, well past the pipeline depth.
    localparam int DRAIN_CYCLES   = 20;
    // Length of the deliberate receiver hold-off that backs the block up.
    localparam int HOLDOFF_CYCLES = 600;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 65;

    localparam logic [COORD_BITS-1:0] COORD_MAX = 16'h7FFF;
    localparam logic [COORD_BITS-1:0] COORD_MIN = 16'h8000;
    localparam logic [COORD_BITS-1:0] EXTREME_COORDS [4] = '{16'h7FFF, 16'h8000,
                                                            16'h0000, 16'hFFFF};

    // Register settings per random segment. They cover the largest and smallest
    // grids, zero values (act as one), and values above the limits (the column
    // count clamps; the subdivision values have bits above bit 1, which are dropped).
    localparam logic [CFG_DATA_BITS-1:0] SEG_COLS   [SEGMENTS] = '{16, 1, 0, 31, 7, 12};
    localparam logic [CFG_DATA_BITS-1:0] SEG_ACROSS [SEGMENTS] = '{2, 1, 0, 31, 6, 9};
    localparam logic [CFG_DATA_BITS-1:0] SEG_DOWN   [SEGMENTS] = '{2, 1, 0, 31, 1, 30};

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    bps_in_t                    in_data;
    logic                       out_valid;
    logic                       out_ready;
    bps_out_t                   out_data;
    logic                       cfg_we;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    int fail_count;
    int points_pending;
    int cycle_count   = 0;
    int send_idle_pct = 14;
    int recv_idle_pct = 81;
    int stall_request = 0;

    bilinear_patch_subdivider u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bps_point_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .points_pending (points_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog. If the run has not finished by the limit, something is hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Receiver side. Each cycle it accepts a point or not according to the
    // current idle rate. When the stimulus asks for a long stall, it holds
    // ready low for a fixed stretch, counted here, so that the block backs up.
    initial
    begin : receiver
        int holdoff_left;
        int stalls_seen;
        out_ready    = 1'b0;
        holdoff_left = 0;
        stalls_seen  = 0;
        forever
        begin
            @(posedge clk);
            if (stall_request != stalls_seen)
            begin
                stalls_seen  = stall_request;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic bps_in_t make_patch(
        input logic [PATCH_BITS-1:0] row, input logic [PATCH_BITS-1:0] col,
        input logic [COORD_BITS-1:0] tlx, input logic [COORD_BITS-1:0] tly,
        input logic [COORD_BITS-1:0] trx, input logic [COORD_BITS-1:0] try_y,
        input logic [COORD_BITS-1:0] blx, input logic [COORD_BITS-1:0] bly,
        input logic [COORD_BITS-1:0] brx, input logic [COORD_BITS-1:0] bry);
        bps_in_t patch;
        patch.patch_row      = row;
        patch.patch_col      = col;
        patch.top_left_x     = tlx;
        patch.top_left_y     = tly;
        patch.top_right_x    = trx;
        patch.top_right_y    = try_y;
        patch.bottom_left_x  = blx;
        patch.bottom_left_y  = bly;
        patch.bottom_right_x = brx;
        patch.bottom_right_y = bry;
        return patch;
    endfunction

    // A coordinate is an extreme value a quarter of the time, a small value near
    // zero a quarter of the time (where rounding ties show up often), and
    // otherwise any 16-bit pattern.
    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(3))
            0:       return EXTREME_COORDS[$urandom_range(3)];
            1:       return COORD_BITS'(int'($urandom_range(16)) - 8);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // Row and column take their full 4-bit range, so columns beyond the
    // configured patch count are exercised as well.
    function automatic bps_in_t random_patch();
        return make_patch(PATCH_BITS'($urandom), PATCH_BITS'($urandom),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    // Offers one patch beat and returns at the edge where it is taken. Valid is
    // lowered only when an idle cycle is actually inserted, so back-to-back beats
    // keep valid high without a glitch.
    task automatic send_patch(input bps_in_t patch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= patch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops offering beats and waits until every predicted point has come out.
    // The first edge lets the checker account for a beat taken at this edge.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on consecutive cycles. Only called while the
    // block is drained.
    task automatic load_settings(input logic [CFG_DATA_BITS-1:0] columns,
                                 input logic [CFG_DATA_BITS-1:0] across,
                                 input logic [CFG_DATA_BITS-1:0] down);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PATCH_COLUMNS;
        cfg_data  <= columns;
        @(posedge clk);
        cfg_index <= CFG_SUBDIV_ACROSS;
        cfg_data  <= across;
        @(posedge clk);
        cfg_index <= CFG_SUBDIV_DOWN;
        cfg_data  <= down;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int seg;
        int k;

        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_PATCH_COLUMNS;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset settings: zero, the coordinate
        // extremes, opposing corners, small values around rounding ties, and
        // the corners of the row and column range (column 15 lies past the
        // single configured patch).
        send_patch(make_patch(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_patch(make_patch(15, 15, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_patch(make_patch(0, 15, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_patch(make_patch(15, 0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                              COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        send_patch(make_patch(3, 1, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                              COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_patch(make_patch(0, 0, 1, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        send_patch(make_patch(0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1));
        send_patch(make_patch(1, 0, 1, 1, 2, 2, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF));
        send_patch(make_patch(5, 10, 4, 16'hFFFB, 16'hFFFC, 5, 0, 9, 16'hFFF7, 0));
        send_patch(make_patch(10, 5, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                              16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
        send_patch(make_patch(7, 8, 16'h0010, 16'h0010, 16'h0040, 16'h0010,
                              16'h0010, 16'h0040, 16'h0040, 16'h0040));
        send_patch(make_patch(8, 7, COORD_MAX, 0, 0, COORD_MAX, 0, COORD_MIN,
                              COORD_MIN, 0));
        send_patch(make_patch(2, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_patch(make_patch(12, 14, 16'h1234, 16'hEDCB, 16'h7F00, 16'h80FF,
                              16'h00FF, 16'hFF00, 16'h4000, 16'hC000));
        send_patch(make_patch(9, 9, 3, 3, 3, 3, 3, 3, 3, 4));

        // Random segments. Idling runs sender-light / receiver-heavy for the
        // first two, the reverse for the next two, and with no idling at all
        // for the last two. Each segment starts from a drained block with new
        // register settings.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_for_drain();
            if (seg < 2)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 81;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_settings(SEG_COLS[seg], SEG_ACROSS[seg], SEG_DOWN[seg]);

            for (k = 0; k < SEGMENT_ITEMS; k++)
            begin
                // With nobody idling, a long receiver stall fills the pipeline
                // while beats keep coming, so the block must push back.
                if (seg == 4 && k == 10)
                    stall_request++;
                // Midway through the last segment the sender stops until every
                // outstanding point has drained, then resumes.
                if (seg == 5 && k == SEGMENT_ITEMS / 2)
                    wait_for_drain();
                send_patch(random_patch());
            end
        end

        wait_for_drain();

        if (fail_count == 0 && points_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
